// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, quiet while reset is high.
`define SAIS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sais assertion failed");

// Property checked on every rising edge, reset included.
`define SAIS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sais assertion failed");

`endif

// ===== rtl/sais_pkg.sv =====
`timescale 1ns / 1ps
package sais_pkg;

  localparam int DEPTH   = 256;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COUNT_W = ADDR_W + 1;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BADPOS   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // datapath micro-operations
  localparam logic [4:0] DP_NONE         = 5'd0;
  localparam logic [4:0] DP_LOAD         = 5'd1;
  localparam logic [4:0] DP_APPEND       = 5'd2;
  localparam logic [4:0] DP_INS_PUT      = 5'd3;
  localparam logic [4:0] DP_RD_IDXM1     = 5'd4;
  localparam logic [4:0] DP_INS_WR       = 5'd5;
  localparam logic [4:0] DP_RD_IDXP1     = 5'd6;
  localparam logic [4:0] DP_DEL_WR       = 5'd7;
  localparam logic [4:0] DP_DEL_END      = 5'd8;
  localparam logic [4:0] DP_RD_POS       = 5'd9;
  localparam logic [4:0] DP_RD_LO        = 5'd10;
  localparam logic [4:0] DP_RD_HI_CAP_LO = 5'd11;
  localparam logic [4:0] DP_CAP_HI       = 5'd12;
  localparam logic [4:0] DP_P_LO         = 5'd13;
  localparam logic [4:0] DP_DIV_INIT     = 5'd14;
  localparam logic [4:0] DP_DIV_STEP     = 5'd15;
  localparam logic [4:0] DP_P_Q          = 5'd16;
  localparam logic [4:0] DP_RD_P         = 5'd17;
  localparam logic [4:0] DP_NARROW       = 5'd18;

  // result register updates
  localparam logic [2:0] RES_NONE  = 3'd0;
  localparam logic [2:0] RES_FULL  = 3'd1;
  localparam logic [2:0] RES_BAD   = 3'd2;
  localparam logic [2:0] RES_NF    = 3'd3;
  localparam logic [2:0] RES_DATA  = 3'd4;
  localparam logic [2:0] RES_FOUND = 3'd5;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [7:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         found_position;
    logic signed [31:0] data_value;
    logic [8:0]         entry_count;
  } rsp_t;

  typedef struct packed {
    logic [4:0] dp;
    logic [2:0] res;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       pos_gt_cnt;
    logic       pos_ge_cnt;
    logic       win_ok;
    logic       in_range;
    logic       ends_eq;
    logic       div_last;
    logic       hit;
    logic       key_gt;
    logic       ins_at_pos;
    logic       del_last;
  } sts_t;

endpackage

// ===== rtl/sais_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sais_datapath import sais_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic [ADDR_W-1:0]  raddr;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic signed [31:0] wdata;

  logic [2:0]          op;
  logic signed [31:0]  key;
  logic [ADDR_W-1:0]   pos;
  logic [COUNT_W-1:0]  count;
  logic signed [COUNT_W:0] lo;
  logic signed [COUNT_W:0] hi;
  logic signed [31:0]  dlo;
  logic signed [31:0]  dhi;
  logic [40:0]         num;
  logic [32:0]         den;
  logic [ADDR_W-1:0]   q;
  logic [2:0]          k;
  logic [ADDR_W-1:0]   p;
  logic [ADDR_W-1:0]   idx;

  logic [1:0]          res_status;
  logic [7:0]          res_found;
  logic signed [31:0]  res_data;

  logic [32:0]         diff;
  logic [7:0]          span;
  logic [40:0]         prod;
  logic [40:0]         shifted;

  always_comb begin
    case (cmd.dp)
      DP_RD_POS:       raddr = pos;
      DP_RD_LO:        raddr = lo[ADDR_W-1:0];
      DP_RD_HI_CAP_LO: raddr = hi[ADDR_W-1:0];
      DP_RD_P:         raddr = p;
      DP_P_Q:          raddr = lo[ADDR_W-1:0] + q;
      DP_RD_IDXM1:     raddr = idx - 1'b1;
      DP_RD_IDXP1:     raddr = idx + 1'b1;
      default:         raddr = pos;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rdata;
    case (cmd.dp)
      DP_APPEND: begin
        we    = 1'b1;
        waddr = count[ADDR_W-1:0];
        wdata = key;
      end
      DP_INS_PUT: begin
        we    = 1'b1;
        waddr = pos;
        wdata = key;
      end
      DP_INS_WR, DP_DEL_WR: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign diff    = 33'($signed({key[31], key}) - $signed({dlo[31], dlo}));
  assign span    = 8'(hi - lo);
  assign prod    = 41'(diff) * 41'(span);
  assign shifted = {8'd0, den} << k;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.dp)
        DP_APPEND, DP_INS_PUT: count <= count + 1'b1;
        DP_DEL_END:            count <= count - 1'b1;
        default:               count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.dp)
      DP_LOAD: begin
        op  <= req.operation;
        key <= req.value;
        pos <= req.position;
        lo  <= '0;
        hi  <= $signed({1'b0, count}) - (COUNT_W+1)'(1);
        idx <= (req.operation == OP_INSERT) ? count[ADDR_W-1:0] : req.position;
      end
      DP_RD_HI_CAP_LO: dlo <= rdata;
      DP_CAP_HI:       dhi <= rdata;
      DP_P_LO: begin
        p <= lo[ADDR_W-1:0];
        q <= '0;
      end
      DP_DIV_INIT: begin
        num <= prod;
        den <= 33'($signed({dhi[31], dhi}) - $signed({dlo[31], dlo}));
        q   <= '0;
        k   <= 3'd7;
      end
      DP_DIV_STEP: begin
        if (num >= shifted) begin
          num  <= num - shifted;
          q[k] <= 1'b1;
        end
        k <= k - 1'b1;
      end
      DP_P_Q: p <= lo[ADDR_W-1:0] + q;
      DP_NARROW: begin
        if (key > rdata) begin
          lo <= $signed({2'b00, p}) + (COUNT_W+1)'(1);
        end else begin
          hi <= $signed({2'b00, p}) - (COUNT_W+1)'(1);
        end
      end
      DP_INS_WR: idx <= idx - 1'b1;
      DP_DEL_WR: idx <= idx + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.dp == DP_LOAD) begin
      res_status <= ST_OK;
      res_found  <= '0;
      res_data   <= '0;
    end else begin
      case (cmd.res)
        RES_FULL:  res_status <= ST_FULL;
        RES_BAD:   res_status <= ST_BADPOS;
        RES_NF:    res_status <= ST_NOTFOUND;
        RES_DATA:  res_data   <= rdata;
        RES_FOUND: res_found  <= p;
        default: ;
      endcase
    end
    if (cmd.publish) begin
      rsp <= '{status: res_status, found_position: res_found,
               data_value: res_data, entry_count: count};
    end
  end

  always_comb begin
    sts.op         = op;
    sts.full       = (count == COUNT_W'(DEPTH));
    sts.pos_gt_cnt = ({1'b0, pos} > count);
    sts.pos_ge_cnt = ({1'b0, pos} >= count);
    sts.win_ok     = (lo <= hi);
    sts.in_range   = (key >= dlo) && (key <= dhi);
    sts.ends_eq    = (dhi == dlo);
    sts.div_last   = (k == 3'd0);
    sts.hit        = (rdata == key);
    sts.key_gt     = (key > rdata);
    sts.ins_at_pos = (idx == pos);
    sts.del_last   = (({1'b0, idx} + 1'b1) >= count);
  end

  `SAIS_ASSERT_ALWAYS(a_reset_clears_count, clk, rst |=> (count == '0))
  `SAIS_ASSERT(a_count_le_depth, clk, rst, count <= COUNT_W'(DEPTH))
  `SAIS_ASSERT(a_count_moves_by_one, clk, rst,
    (count == $past(count)) || (count == $past(count) + 1'b1) || (count == $past(count) - 1'b1))

endmodule

// ===== rtl/sais_controller.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sais_controller import sais_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_WR  = 4'd3;
  localparam logic [3:0] S_DEL_CAP = 4'd4;
  localparam logic [3:0] S_DEL_RD  = 4'd5;
  localparam logic [3:0] S_DEL_WR  = 4'd6;
  localparam logic [3:0] S_RD_CAP  = 4'd7;
  localparam logic [3:0] S_SR_LOOP = 4'd8;
  localparam logic [3:0] S_SR_RLO  = 4'd9;
  localparam logic [3:0] S_SR_RHI  = 4'd10;
  localparam logic [3:0] S_SR_CHK  = 4'd11;
  localparam logic [3:0] S_SR_DIV  = 4'd12;
  localparam logic [3:0] S_SR_PRD  = 4'd13;
  localparam logic [3:0] S_SR_PCMP = 4'd14;
  localparam logic [3:0] S_DONE    = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.dp      = DP_NONE;
    cmd.res     = RES_NONE;
    cmd.publish = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.dp     = DP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (sts.op)
          OP_APPEND: begin
            if (sts.full) cmd.res = RES_FULL;
            else          cmd.dp  = DP_APPEND;
          end
          OP_INSERT: begin
            if (sts.full)            cmd.res = RES_FULL;
            else if (sts.pos_gt_cnt) cmd.res = RES_BAD;
            else                     state_next = S_INS_RD;
          end
          OP_DELETE: begin
            if (sts.pos_ge_cnt) begin
              cmd.res = RES_BAD;
            end else begin
              cmd.dp     = DP_RD_POS;
              state_next = S_DEL_CAP;
            end
          end
          OP_READ: begin
            if (sts.pos_ge_cnt) begin
              cmd.res = RES_BAD;
            end else begin
              cmd.dp     = DP_RD_POS;
              state_next = S_RD_CAP;
            end
          end
          OP_SEARCH: state_next = S_SR_LOOP;
          default:   state_next = S_DONE;
        endcase
      end
      // shift up from the top, one entry per S_INS_RD/S_INS_WR pass
      S_INS_RD: begin
        if (sts.ins_at_pos) begin
          cmd.dp     = DP_INS_PUT;
          state_next = S_DONE;
        end else begin
          cmd.dp     = DP_RD_IDXM1;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.dp     = DP_INS_WR;
        state_next = S_INS_RD;
      end
      S_DEL_CAP: begin
        cmd.res    = RES_DATA;
        state_next = S_DEL_RD;
      end
      S_DEL_RD: begin
        if (sts.del_last) begin
          cmd.dp     = DP_DEL_END;
          state_next = S_DONE;
        end else begin
          cmd.dp     = DP_RD_IDXP1;
          state_next = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.dp     = DP_DEL_WR;
        state_next = S_DEL_RD;
      end
      S_RD_CAP: begin
        cmd.res    = RES_DATA;
        state_next = S_DONE;
      end
      S_SR_LOOP: begin
        if (sts.win_ok) begin
          cmd.dp     = DP_RD_LO;
          state_next = S_SR_RLO;
        end else begin
          cmd.res    = RES_NF;
          state_next = S_DONE;
        end
      end
      S_SR_RLO: begin
        cmd.dp     = DP_RD_HI_CAP_LO;
        state_next = S_SR_RHI;
      end
      S_SR_RHI: begin
        cmd.dp     = DP_CAP_HI;
        state_next = S_SR_CHK;
      end
      S_SR_CHK: begin
        if (!sts.in_range) begin
          cmd.res    = RES_NF;
          state_next = S_DONE;
        end else if (sts.ends_eq) begin
          cmd.dp     = DP_P_LO;
          state_next = S_SR_PRD;
        end else begin
          cmd.dp     = DP_DIV_INIT;
          state_next = S_SR_DIV;
        end
      end
      // one quotient bit per cycle; probe address follows the last bit
      S_SR_DIV: begin
        cmd.dp = DP_DIV_STEP;
        if (sts.div_last) begin
          state_next = S_SR_PRD;
        end
      end
      S_SR_PRD: begin
        cmd.dp     = DP_P_Q;
        state_next = S_SR_PCMP;
      end
      S_SR_PCMP: begin
        if (sts.hit) begin
          cmd.res    = RES_FOUND;
          state_next = S_DONE;
        end else begin
          cmd.dp     = DP_NARROW;
          state_next = S_SR_LOOP;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.publish) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  `SAIS_ASSERT(a_accept_to_decode, clk, rst, (req_valid && req_ready) |=> (state == S_DECODE))
  `SAIS_ASSERT(a_publish_shows, clk, rst, cmd.publish |=> (rsp_valid && state == S_IDLE))
  `SAIS_ASSERT(a_no_publish_over_pending, clk, rst,
    (rsp_valid && !rsp_ready) |-> !cmd.publish)

endmodule

// ===== rtl/sorted_array_interpolation_search.sv =====
`timescale 1ns / 1ps
// Sorted array with interpolation search, 256 signed 32-bit entries.
// Request channel (req_valid/req_ready/req): one operation per item, append,
// insert, delete, search or read. Response channel (rsp_valid/rsp_ready/rsp):
// exactly one item per request, with status, found position, data and count.
// Requests are taken one at a time; req_ready is high while the block is idle.
// Each item runs through a decode state and ends in a done state that publishes
// the result. Append, rejected ops and unused codes go from decode to done; read
// adds a data capture; insert moves entries position..count-1 up by one from the
// top, delete captures the entry and moves the ones above it down by one. Search
// repeats probes (two entry reads, a check, an 8-step shift-subtract divide, one
// probe read; no divide when the window ends are equal) until a hit or a miss;
// the probe count depends on the data. The entry store has one read port, so
// shift steps read then write, and window ends are read one after the other.
// A finished response sits in an output register; the next request is taken
// while it waits, and a further result is held until the receiver takes it.
// Reset clears the count and the handshake state; entries are not cleared.
module sorted_array_interpolation_search import sais_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  sais_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sais_datapath u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule
